[design/strong_probable_prime_test_defines.svh]
// ----------------------------------------------------------------------------
// strong_probable_prime_test_defines
// Assertion macros shared by the design files.
// ----------------------------------------------------------------------------
`ifndef STRONG_PROBABLE_PRIME_TEST_DEFINES_SVH
`define STRONG_PROBABLE_PRIME_TEST_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SPRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a signal is one-hot or zero at every clock edge outside reset.
`define SPRP_ONEHOT0(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);

`endif

[design/sprp_pkg.sv]
// ----------------------------------------------------------------------------
// sprp_pkg
// Types and constants for the strong probable prime test block.
// ----------------------------------------------------------------------------
package sprp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef struct packed {
        logic [31:0] candidate;
        logic [31:0] base;
    } sprp_in_t;

    typedef struct packed {
        logic probable_prime;
        logic invalid_candidate;
    } sprp_out_t;

    // Modular multiplier request.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
        logic [WIDTH-1:0] n;
    } sprp_mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_REDUCE,
        ST_EXP_MUL,
        ST_EXP_WAIT_MUL,
        ST_EXP_SQR,
        ST_EXP_WAIT_SQR,
        ST_CHECK,
        ST_SQR,
        ST_SQR_WAIT,
        ST_DONE
    } sprp_state_t;

    // (x + y) mod n for x, y < n.
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] n);
        logic [WIDTH-1:0] room;
        room = n - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

endpackage

[design/sprp_mulmod.sv]
// ----------------------------------------------------------------------------
// sprp_mulmod
// Bit-serial modular multiplier: one bit of y per cycle, shift-and-add.
// ----------------------------------------------------------------------------
`include "strong_probable_prime_test_defines.svh"

module sprp_mulmod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sprp_pkg::sprp_mul_req_t        req,
    output logic                           busy,
    output logic                           done,
    output logic [sprp_pkg::WIDTH-1:0]     result
);
    import sprp_pkg::*;

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
            n_next    = req.n;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = add_mod(acc_reg, x_reg, n_reg);
                end
                x_next = add_mod(x_reg, x_reg, n_reg);
                y_next = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

    `SPRP_ASSERT(a_done_after_busy, clk, rst_n, done_reg |-> $past(busy_reg), "done without busy")
    `SPRP_ASSERT(a_no_busy_done, clk, rst_n, done_reg |-> !busy_reg, "done while busy")
    `SPRP_ASSERT(a_acc_below_n, clk, rst_n, (busy_reg && !req.start) |-> (acc_reg < n_reg), "accumulator not reduced")

endmodule

[design/strong_probable_prime_test.sv]
// ----------------------------------------------------------------------------
// strong_probable_prime_test
// One Miller-Rabin round on a 32-bit candidate with a given witness base.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in/in_valid/in_stall carries candidate and base. Output
//   channel out/out_valid/out_stall carries probable_prime and
//   invalid_candidate, one transaction per input transaction.
//   The block works on one item at a time: in_stall is high from acceptance
//   until the result has been taken.
//   Sequence: the base reduction and every modular product run through one
//   bit-serial multiplier. The base is reduced by multiplying by 1, then the
//   bits of t cost up to two products each and the squarings one each; t and
//   the power of two share WIDTH bits. Candidates below two go straight to
//   the result without using the multiplier.
//   Reset clears the sequencer and drops any item in flight. While out_stall
//   is high, the result is held and no new item is taken.
// ----------------------------------------------------------------------------
`include "strong_probable_prime_test_defines.svh"

module strong_probable_prime_test (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sprp_pkg::sprp_in_t    in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sprp_pkg::sprp_out_t   out
);
    import sprp_pkg::*;

    sprp_state_t      state_reg, state_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] nm1_reg, nm1_next;
    logic [WIDTH-1:0] t_reg, t_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [CNT_W-1:0] s_reg, s_next;
    sprp_out_t        res_reg, res_next;

    sprp_mul_req_t    mreq;
    logic             mbusy;
    logic             mdone;
    logic [WIDTH-1:0] mres;

    sprp_mulmod u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .busy   (mbusy),
        .done   (mdone),
        .result (mres)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (in.candidate[WIDTH-1:0] < 2) ? ST_DONE : ST_SPLIT;
            ST_SPLIT:
                if (t_reg[0])
                    state_next = ST_REDUCE;
            ST_REDUCE:
                if (mdone)
                    state_next = ST_EXP_MUL;
            ST_EXP_MUL:
                if (t_reg == '0)
                    state_next = ST_CHECK;
                else if (t_reg[0])
                    state_next = ST_EXP_WAIT_MUL;
                else
                    state_next = ST_EXP_SQR;
            ST_EXP_WAIT_MUL:
                if (mdone)
                    state_next = ST_EXP_SQR;
            ST_EXP_SQR:
                state_next = ST_EXP_WAIT_SQR;
            ST_EXP_WAIT_SQR:
                if (mdone)
                    state_next = ST_EXP_MUL;
            ST_CHECK:
                if (x_reg == 1 || x_reg == nm1_reg || s_reg <= 1)
                    state_next = ST_DONE;
                else
                    state_next = ST_SQR;
            ST_SQR:
                state_next = ST_SQR_WAIT;
            ST_SQR_WAIT:
                if (mdone)
                    state_next = (mres == nm1_reg || s_reg <= 2) ? ST_DONE : ST_SQR;
            ST_DONE:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and multiplier requests.
    always_comb
    begin
        n_next   = n_reg;
        nm1_next = nm1_reg;
        t_next   = t_reg;
        a_next   = a_reg;
        x_next   = x_reg;
        s_next   = s_reg;
        res_next = res_reg;
        mreq     = '{start: 1'b0, x: a_reg, y: a_reg, n: n_reg};
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    n_next   = in.candidate[WIDTH-1:0];
                    nm1_next = in.candidate[WIDTH-1:0] - 1'b1;
                    t_next   = in.candidate[WIDTH-1:0] - 1'b1;
                    a_next   = in.base[WIDTH-1:0];
                    x_next   = {{(WIDTH-1){1'b0}}, 1'b1};
                    s_next   = '0;
                    res_next = '{probable_prime: 1'b0,
                                 invalid_candidate: in.candidate[WIDTH-1:0] < 2};
                end
            ST_SPLIT:
                if (!t_reg[0])
                begin
                    t_next = t_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    // a mod n as a product of 1 and a, reduced bit by bit.
                    mreq = '{start: 1'b1, x: {{(WIDTH-1){1'b0}}, n_reg != 1},
                             y: a_reg, n: n_reg};
                end
            ST_REDUCE:
                if (mdone)
                    a_next = mres;
            ST_EXP_MUL:
                if (t_reg != '0)
                begin
                    if (t_reg[0])
                        mreq = '{start: 1'b1, x: x_reg, y: a_reg, n: n_reg};
                end
            ST_EXP_WAIT_MUL:
                if (mdone)
                    x_next = mres;
            ST_EXP_SQR:
                mreq = '{start: 1'b1, x: a_reg, y: a_reg, n: n_reg};
            ST_EXP_WAIT_SQR:
                if (mdone)
                begin
                    a_next = mres;
                    t_next = t_reg >> 1;
                end
            ST_CHECK:
                begin
                    res_next.probable_prime = (x_reg == 1 || x_reg == nm1_reg);
                end
            ST_SQR:
                mreq = '{start: 1'b1, x: x_reg, y: x_reg, n: n_reg};
            ST_SQR_WAIT:
                if (mdone)
                begin
                    x_next = mres;
                    s_next = s_reg - 1'b1;
                    res_next.probable_prime = (mres == nm1_reg);
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        nm1_reg <= nm1_next;
        t_reg   <= t_next;
        a_reg   <= a_next;
        x_reg   <= x_next;
        s_reg   <= s_next;
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out       = res_reg;

    `SPRP_ASSERT(a_out_held, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out)), "stalled result changed")
    `SPRP_ASSERT(a_invalid_fails, clk, rst_n, (out_valid && out.invalid_candidate) |-> !out.probable_prime, "invalid candidate passed")
    `SPRP_ASSERT(a_mul_idle_on_start, clk, rst_n, mreq.start |-> !mbusy, "multiplier restarted while busy")
    `SPRP_ONEHOT0(a_one_side, clk, rst_n, {out_valid, !in_stall}, "input and output open together")

endmodule
